// File: rtl/core/ptc_pkg.sv
`default_nettype none

package ptc_pkg;

    // One input transaction: a raw sensor sample pair
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } sample_t;

    // One result transaction
    typedef struct packed {
        logic signed [23:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
    } result_t;

    // Sideband that rides along the divider pipeline
    typedef struct packed {
        logic               nz;
        logic signed [23:0] temp;
    } ptc_tag_t;

    // Configuration register indexes
    localparam int CfgIdxW = 2;
    typedef enum logic [CfgIdxW-1:0] {
        REG_TEMP_CAL   = 2'd0,
        REG_PRESS_LOW  = 2'd1,
        REG_PRESS_HIGH = 2'd2,
        REG_PRESS_LAST = 2'd3
    } cfg_reg_e;

    localparam int DataW       = 64;
    localparam int DivW        = 64;
    localparam int FineOffset  = 128000;
    localparam int PressBase   = 1048576;
    localparam int PressScale  = 3125;

endpackage

`default_nettype wire

// File: rtl/core/ptc_div.sv
`default_nettype none

// Pipelined signed divider, one quotient bit per stage, truncates toward zero.
// Accepts one operand pair every cycle.
module ptc_div
    import ptc_pkg::*;
#(
    parameter int W = DivW
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic signed [W-1:0] num,
    input  wire logic signed [W-1:0] den,
    input  wire ptc_tag_t            in_tag,
    output logic                     out_valid,
    output logic signed [W-1:0]      quot,
    output ptc_tag_t                 out_tag
);

    logic [W-1:0] rem_reg [0:W];
    logic [W-1:0] quo_reg [0:W];
    logic [W-1:0] dvs_reg [0:W];
    logic         neg_reg [0:W];
    ptc_tag_t     tag_reg [0:W];
    logic         vld_reg [0:W];

    logic [W-1:0] ua_next;
    logic [W-1:0] ub_next;

    // Magnitudes and result sign
    assign ua_next = num[W-1] ? (~num + 1'b1) : num;
    assign ub_next = den[W-1] ? (~den + 1'b1) : den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        quo_reg[0] <= ua_next;
        dvs_reg[0] <= ub_next;
        neg_reg[0] <= num[W-1] ^ den[W-1];
        tag_reg[0] <= in_tag;
    end

    // Restoring iterations, one bit per stage
    for (genvar k = 1; k <= W; k++)
    begin : g_iter
        logic [W:0] shifted;
        logic [W:0] diff;
        logic       ge;

        assign shifted = {rem_reg[k-1], quo_reg[k-1][W-1]};
        assign diff    = shifted - {1'b0, dvs_reg[k-1]};
        assign ge      = ~diff[W];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? diff[W-1:0] : shifted[W-1:0];
            quo_reg[k] <= {quo_reg[k-1][W-2:0], ge};
            dvs_reg[k] <= dvs_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            tag_reg[k] <= tag_reg[k-1];
        end
    end

    // Sign fix-up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= vld_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        quot    <= neg_reg[W] ? (~quo_reg[W] + 1'b1) : quo_reg[W];
        out_tag <= tag_reg[W];
    end

endmodule

`default_nettype wire

// File: rtl/core/pressure_temp_compensation.sv
`default_nettype none

// Barometric temperature / pressure compensation, 64-bit integer scheme.
// Input: start with sample (raw 20-bit temperature and pressure). A sample is
// taken at every clock edge where start is high and busy is low; busy stays
// low, so one sample per cycle is taken.
// Output: done pulses for one cycle with result (temperature in 0.01 degree,
// pressure in Pa as unsigned Q24.8, pressure_valid). Results come out in
// order.
// Pipeline: 10 front stages of polynomial math, the 66-stage divider (one
// quotient bit per stage), then 4 correction stages and the output register.
// Throughput: one sample per clock.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// calibration word, cfg_data the value. cfg_ready is always high. Write only
// while no samples are in flight.
// Reset: rst_n clears calibration words to zero and empties the pipeline.
// The receiver cannot stall; each result is shown for one cycle only.
module pressure_temp_compensation
    import ptc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire sample_t             sample,
    output logic                     done,
    output result_t                  result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [DataW-1:0]    cfg_data
);

    localparam int FrontN = 10;
    localparam int PostN  = 4;

    // ---------------- configuration ----------------
    logic [47:0] tcal_reg;
    logic [63:0] plow_reg;
    logic [63:0] phigh_reg;
    logic [15:0] plast_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg  <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            plast_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_TEMP_CAL:   tcal_reg  <= cfg_data[47:0];
                REG_PRESS_LOW:  plow_reg  <= cfg_data;
                REG_PRESS_HIGH: phigh_reg <= cfg_data;
                REG_PRESS_LAST: plast_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    logic        [15:0] t1;
    logic signed [15:0] t2, t3;
    logic        [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = tcal_reg[15:0];
    assign t2 = tcal_reg[31:16];
    assign t3 = tcal_reg[47:32];
    assign p1 = plow_reg[15:0];
    assign p2 = plow_reg[31:16];
    assign p3 = plow_reg[47:32];
    assign p4 = plow_reg[63:48];
    assign p5 = phigh_reg[15:0];
    assign p6 = phigh_reg[31:16];
    assign p7 = phigh_reg[47:32];
    assign p8 = phigh_reg[63:48];
    assign p9 = plast_reg;

    // ---------------- front pipeline valid and carries ----------------
    logic        fv_reg   [1:FrontN];
    logic [19:0] padc_reg [1:8];
    logic signed [23:0] temp_reg [5:FrontN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= FrontN; i++)
            begin
                fv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            fv_reg[1] <= start && !busy;
            for (int i = 2; i <= FrontN; i++)
            begin
                fv_reg[i] <= fv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        padc_reg[1] <= sample.raw_pressure;
        for (int i = 2; i <= 8; i++)
        begin
            padc_reg[i] <= padc_reg[i-1];
        end
        for (int i = 6; i <= FrontN; i++)
        begin
            temp_reg[i] <= temp_reg[i-1];
        end
    end

    // Stage 1: offsets from T1
    logic signed [18:0] d1_next, d1_reg;
    logic signed [17:0] d2_next, d2_reg;
    assign d1_next = signed'({2'b00, sample.raw_temperature[19:3]})
                   - signed'({2'b00, t1, 1'b0});
    assign d2_next = signed'({2'b00, sample.raw_temperature[19:4]})
                   - signed'({2'b00, t1});

    // Stage 2: first products
    logic signed [34:0] m1_next, m1_reg;
    logic signed [35:0] sq_next, sq_reg;
    assign m1_next = d1_reg * t2;
    assign sq_next = d2_reg * d2_reg;

    // Stage 3: scale and T3 product
    logic signed [23:0] v1t_next, v1t_reg;
    logic signed [23:0] sqs;
    logic signed [39:0] m3_next, m3_reg;
    assign v1t_next = m1_reg[34:11];
    assign sqs      = sq_reg[35:12];
    assign m3_next  = sqs * t3;

    // Stage 4: fine temperature
    logic signed [25:0] m3s;
    logic signed [26:0] v1t_x, m3_x;
    logic signed [26:0] fine_next, fine_reg;
    assign m3s       = m3_reg[39:14];
    assign v1t_x     = 27'(v1t_reg);
    assign m3_x      = 27'(m3s);
    assign fine_next = v1t_x + m3_x;

    // Stage 5: temperature result and pressure offset
    logic signed [29:0] fine_x, tcs;
    logic signed [21:0] tc;
    logic signed [27:0] fine_y;
    logic signed [27:0] vp_next, vp_reg;
    assign fine_x  = 30'(fine_reg);
    assign tcs     = (fine_x <<< 2) + fine_x + 30'sd128;
    assign tc      = tcs[29:8];
    assign fine_y  = 28'(fine_reg);
    assign vp_next = fine_y - 28'(FineOffset);

    // Stage 6: square and linear terms
    logic signed [55:0] vv_next, vv_reg;
    logic signed [43:0] mp5_next, mp5_reg, mp2_next, mp2_reg;
    assign vv_next  = vp_reg * vp_reg;
    assign mp5_next = vp_reg * p5;
    assign mp2_next = vp_reg * p2;

    // Stage 7: square times P6 and P3, kept to 64 bits
    logic signed [71:0] x6_full, x3_full;
    logic signed [63:0] x6_reg, x3_reg;
    logic        [43:0] mp5_d_reg;
    logic signed [43:0] mp2_d_reg;
    assign x6_full = vv_reg * p6;
    assign x3_full = vv_reg * p3;

    // Stage 8: sum terms
    logic signed [63:0] mp5_x, mp2_x, p4_x, x3s;
    logic [63:0] v2_next, v2_reg, v1b_next, v1b_reg;
    assign mp5_x    = 64'(signed'(mp5_d_reg));
    assign mp2_x    = 64'(mp2_d_reg);
    assign p4_x     = 64'(p4);
    assign x3s      = x3_reg >>> 8;
    assign v2_next  = x6_reg + (mp5_x << 17) + (p4_x << 35);
    assign v1b_next = x3s + (mp2_x << 12) + (64'd1 << 47);

    // Stage 9: P1 product and numerator base
    logic [20:0] pp;
    logic [63:0] pm_next, diff_next, diff_reg;
    logic signed [63:0] pm_reg;
    assign pp        = 21'(PressBase) - {1'b0, padc_reg[8]};
    assign pm_next   = v1b_reg * {48'd0, p1};
    assign diff_next = {12'd0, pp, 31'd0} - v2_reg;

    // Stage 10: numerator scale and divisor
    logic signed [63:0] num_reg, den_reg;
    logic [63:0] num_next;
    logic signed [63:0] den_next;
    logic nz_reg;
    assign num_next = diff_reg * 64'(PressScale);
    assign den_next = pm_reg >>> 33;

    always_ff @(posedge clk)
    begin
        d1_reg      <= d1_next;
        d2_reg      <= d2_next;
        m1_reg      <= m1_next;
        sq_reg      <= sq_next;
        v1t_reg     <= v1t_next;
        m3_reg      <= m3_next;
        fine_reg    <= fine_next;
        temp_reg[5] <= 24'(tc);
        vp_reg      <= vp_next;
        vv_reg      <= vv_next;
        mp5_reg     <= mp5_next;
        mp2_reg     <= mp2_next;
        x6_reg      <= x6_full[63:0];
        x3_reg      <= x3_full[63:0];
        mp5_d_reg   <= mp5_reg;
        mp2_d_reg   <= mp2_reg;
        v2_reg      <= v2_next;
        v1b_reg     <= v1b_next;
        pm_reg      <= pm_next;
        diff_reg    <= diff_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        nz_reg      <= (den_next != '0);
    end

    // ---------------- divider ----------------
    ptc_tag_t           div_tag_in, div_tag_out;
    logic               div_valid;
    logic signed [63:0] div_q;

    assign div_tag_in = '{nz: nz_reg, temp: temp_reg[FrontN]};

    ptc_div #(
        .W (DivW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv_reg[FrontN]),
        .num       (num_reg),
        .den       (den_reg),
        .in_tag    (div_tag_in),
        .out_valid (div_valid),
        .quot      (div_q),
        .out_tag   (div_tag_out)
    );

    // ---------------- correction pipeline ----------------
    logic               pv_reg  [1:PostN];
    ptc_tag_t           ptag_reg[1:PostN];
    logic signed [63:0] q_reg   [1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= PostN; i++)
            begin
                pv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            pv_reg[1] <= div_valid;
            for (int i = 2; i <= PostN; i++)
            begin
                pv_reg[i] <= pv_reg[i-1];
            end
        end
    end

    // Post stage A: scaled quotient, P9 and P8 products
    logic signed [63:0] xs, p9_x, p8_x;
    logic signed [63:0] x_reg, y_reg, bm_reg[1:3];
    logic signed [63:0] y_next, bm_next;
    assign xs      = div_q >>> 13;
    assign p9_x    = 64'(p9);
    assign p8_x    = 64'(p8);
    assign y_next  = xs * p9_x;
    assign bm_next = div_q * p8_x;

    // Post stage B: 64-bit product from 32-bit partial products
    logic [63:0] pp0_next, pp0_reg;
    logic [31:0] pp1_next, pp1_reg, pp2_next, pp2_reg;
    assign pp0_next = y_reg[31:0] * x_reg[31:0];
    assign pp1_next = y_reg[31:0] * x_reg[63:32];
    assign pp2_next = y_reg[63:32] * x_reg[31:0];

    // Post stage C: assemble product
    logic [63:0] prod_next;
    logic signed [63:0] prod_reg;
    assign prod_next = pp0_reg + {pp1_reg + pp2_reg, 32'd0};

    // Post stage D: sum of corrections
    logic signed [63:0] prods, bms, s_next, s_reg;
    assign prods  = prod_reg >>> 25;
    assign bms    = bm_reg[3] >>> 19;
    assign s_next = q_reg[3] + prods + bms;

    always_ff @(posedge clk)
    begin
        ptag_reg[1] <= div_tag_out;
        for (int i = 2; i <= PostN; i++)
        begin
            ptag_reg[i] <= ptag_reg[i-1];
        end
        q_reg[1]  <= div_q;
        q_reg[2]  <= q_reg[1];
        q_reg[3]  <= q_reg[2];
        bm_reg[1] <= bm_next;
        bm_reg[2] <= bm_reg[1];
        bm_reg[3] <= bm_reg[2];
        x_reg     <= xs;
        y_reg     <= y_next;
        pp0_reg   <= pp0_next;
        pp1_reg   <= pp1_next;
        pp2_reg   <= pp2_next;
        prod_reg  <= prod_next;
        s_reg     <= s_next;
    end

    // Output stage: final offset and saturation
    logic signed [63:0] ss, p7_x, f;
    logic [31:0] press_sat;
    assign ss   = s_reg >>> 8;
    assign p7_x = 64'(p7);
    assign f    = ss + (p7_x <<< 4);

    always_comb
    begin
        if (f[63])
        begin
            press_sat = '0;
        end
        else if (|f[62:32])
        begin
            press_sat = '1;
        end
        else
        begin
            press_sat = f[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= pv_reg[PostN];
        end
    end

    always_ff @(posedge clk)
    begin
        result.temperature_centi <= ptag_reg[PostN].temp;
        result.pressure_valid    <= ptag_reg[PostN].nz;
        result.pressure_q24_8    <= ptag_reg[PostN].nz ? press_sat : '0;
    end

endmodule

`default_nettype wire

// File: rtl/core/ptc_checker.sv
`default_nettype none

// Port-level checks for the compensation block
module ptc_port_checks
    import ptc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);

    // Every accepted transaction yields a result; done is registered at the end
    // of the front, divider and correction pipelines
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##81 done)
        else $error("result missing 81 cycles after accept");

    // No result without a matching accept
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##81 !done)
        else $error("result without accepted transaction");

    // Invalid pressure reads as zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.pressure_valid) |-> (result.pressure_q24_8 == '0))
        else $error("nonzero pressure with valid flag clear");

endmodule

bind pressure_temp_compensation ptc_port_checks u_ptc_checker (.*);

`default_nettype wire
